// ----- sv/tun_pkg.sv -----
// Shared constants of the triangle unit normal pipeline.
// Depends on nothing; the top level and the testbench use it.
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
  // Number of vector components (x, y, z).
  localparam int AXES = 3;
  // Integer bits of the normal format above its fraction (sign and one unit bit).
  localparam int NORM_INT_BITS = 2;
endpackage
`default_nettype wire

// ----- sv/tun_vtx_if.sv -----
// Triangle request channel: valid, ready and three signed vertices.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tun_vtx_if #(
  parameter int COORD_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] ax, ay, az;
  logic signed [COORD_WIDTH-1:0] bx, by, bz;
  logic signed [COORD_WIDTH-1:0] cx, cy, cz;
  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface
`default_nettype wire

// ----- sv/tun_nrm_if.sv -----
// Unit normal result channel: valid, ready, three signed components and a flag.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tun_nrm_if #(
  parameter int NORMAL_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [NORMAL_WIDTH-1:0] nx, ny, nz;
  logic degenerate;
  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface
`default_nettype wire

// ----- sv/triangle_unit_normal.sv -----
// Top level of the triangle unit normal pipeline.
// Depends on tun_pkg, tun_vtx_if and tun_nrm_if.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel    modport  payload                         meaning
//  vertices   sink     ax..cz, COORD_WIDTH each         triangle request
//  normal     source   nx, ny, nz, degenerate           unit normal request
//
// One request enters per cycle while the pipeline is not held. There are
// RB = 2*COORD_WIDTH + 3 square-root stages (one per root bit) and
// FB + 1 = NORMAL_WIDTH - 1 divider stages (one per quotient bit).
// Reset clears only the valid bits; the data registers need no reset.
// The whole pipeline advances together; it holds when the output register is
// full and the sink is not ready, so nothing is dropped or repeated.
module triangle_unit_normal #(
  parameter int COORD_WIDTH  = 16,
  parameter int NORMAL_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tun_vtx_if.sink   vertices,
  tun_nrm_if.source normal
);
  localparam int AX   = tun_pkg::AXES;
  localparam int EW   = COORD_WIDTH + 1;     // edge vector width
  localparam int PW   = 2 * EW;              // product width
  localparam int NCW  = PW + 1;              // signed cross product width
  localparam int MW   = PW;                  // magnitude width
  localparam int LOW  = MW / 2;              // low half for split squaring
  localparam int HIW  = MW - LOW;
  localparam int SQW  = 2 * MW;              // square width
  localparam int SUMW = SQW + 2;             // sum of three squares
  localparam int RB   = (SUMW + 1) / 2;      // root bits
  localparam int SRW  = 2 * RB;              // square-root datapath width
  localparam int FB   = NORMAL_WIDTH - tun_pkg::NORM_INT_BITS;
  localparam int QS   = FB + 1;              // quotient bits
  localparam int D    = 7 + RB + QS;         // pipeline depth

  // Stage map: 0 edges, 1 products, 2 cross and magnitude, 3 partial squares,
  // 4 squares, 5 sum, 6..5+RB root, 6+RB..5+RB+QS divide, D-1 output.
  localparam int S_MAG  = 2;
  localparam int S_SUM  = 5;
  localparam int S_ROOT = 6;
  localparam int S_DIV  = 6 + RB;

  logic [D-1:0] vld;
  logic en;

  assign en             = ~vld[D-1] | normal.ready;
  assign vertices.ready = en;
  assign normal.valid   = vld[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], vertices.valid};
    end
  end

  // Stage 0: edges E1 = B - A, E2 = C - A.
  logic signed [EW-1:0] e1 [AX];
  logic signed [EW-1:0] e2 [AX];
  always_ff @(posedge clk) begin
    if (en) begin
      e1[0] <= $signed({vertices.bx[COORD_WIDTH-1], vertices.bx})
             - $signed({vertices.ax[COORD_WIDTH-1], vertices.ax});
      e1[1] <= $signed({vertices.by[COORD_WIDTH-1], vertices.by})
             - $signed({vertices.ay[COORD_WIDTH-1], vertices.ay});
      e1[2] <= $signed({vertices.bz[COORD_WIDTH-1], vertices.bz})
             - $signed({vertices.az[COORD_WIDTH-1], vertices.az});
      e2[0] <= $signed({vertices.cx[COORD_WIDTH-1], vertices.cx})
             - $signed({vertices.ax[COORD_WIDTH-1], vertices.ax});
      e2[1] <= $signed({vertices.cy[COORD_WIDTH-1], vertices.cy})
             - $signed({vertices.ay[COORD_WIDTH-1], vertices.ay});
      e2[2] <= $signed({vertices.cz[COORD_WIDTH-1], vertices.cz})
             - $signed({vertices.az[COORD_WIDTH-1], vertices.az});
    end
  end

  // Stage 1: the six products of the cross product, each pair subtracted next.
  logic signed [PW-1:0] pa [AX];
  logic signed [PW-1:0] pb [AX];
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= e1[1] * e2[2];
      pb[0] <= e1[2] * e2[1];
      pa[1] <= e2[0] * e1[2];
      pb[1] <= e1[0] * e2[2];
      pa[2] <= e1[0] * e2[1];
      pb[2] <= e2[0] * e1[1];
    end
  end

  // Side data that travels with every request: magnitudes, signs, zero flag.
  logic [AX-1:0][MW-1:0] mag_p [D];
  logic [AX-1:0]         neg_p [D];
  logic                  deg_p [D];

  // Stage 2: cross product, split into sign and magnitude.
  logic signed [NCW-1:0] ncr [AX];
  logic [AX-1:0][MW-1:0] mag_c;
  logic [AX-1:0]         neg_c;
  always_comb begin
    for (int k = 0; k < AX; k++) begin
      ncr[k]   = {pa[k][PW-1], pa[k]} - {pb[k][PW-1], pb[k]};
      neg_c[k] = ncr[k][NCW-1];
      mag_c[k] = neg_c[k] ? MW'(-ncr[k]) : MW'(ncr[k]);
    end
  end

  // Stage 3: partial squares from the high and low halves of each magnitude.
  logic [2*HIW-1:0]     sq_hh [AX];
  logic [HIW+LOW-1:0]   sq_hl [AX];
  logic [2*LOW-1:0]     sq_ll [AX];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AX; k++) begin
        sq_hh[k] <= mag_p[S_MAG][k][MW-1:LOW] * mag_p[S_MAG][k][MW-1:LOW];
        sq_hl[k] <= mag_p[S_MAG][k][MW-1:LOW] * mag_p[S_MAG][k][LOW-1:0];
        sq_ll[k] <= mag_p[S_MAG][k][LOW-1:0] * mag_p[S_MAG][k][LOW-1:0];
      end
    end
  end

  // Stage 4: full squares, mag^2 = hh*2^(2L) + 2*hl*2^L + ll.
  logic [SQW-1:0] sq [AX];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AX; k++) begin
        sq[k] <= (SQW'(sq_hh[k]) << (2 * LOW)) + (SQW'(sq_hl[k]) << (LOW + 1))
               + SQW'(sq_ll[k]);
      end
    end
  end

  // Stage 5 and the root stages: digit-by-digit square root, one bit per stage.
  logic [SRW-1:0] op  [RB+1];
  logic [SRW-1:0] res [RB+1];
  always_ff @(posedge clk) begin
    if (en) begin
      op[0]  <= SRW'(SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]));
      res[0] <= '0;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_root
    localparam logic [SRW-1:0] ONE = SRW'(1) << (2 * (RB - 1 - j));
    logic [SRW-1:0] trial;
    assign trial = res[j] + ONE;
    always_ff @(posedge clk) begin
      if (en) begin
        if (op[j] >= trial) begin
          op[j+1]  <= op[j] - trial;
          res[j+1] <= (res[j] >> 1) + ONE;
        end else begin
          op[j+1]  <= op[j];
          res[j+1] <= res[j] >> 1;
        end
      end
    end
  end

  // Divider stages: restoring division of mag * 2^FB by the root, one
  // quotient bit per stage, three lanes side by side.
  logic [RB-1:0] len [QS+1];
  logic [AX-1:0][RB:0]   rem [QS+1];
  logic [AX-1:0][QS-1:0] quo [QS+1];

  always_comb begin
    len[0] = res[RB][RB-1:0];
    quo[0] = '0;
    for (int k = 0; k < AX; k++) begin
      rem[0][k] = {{(RB+1-MW){1'b0}}, mag_p[S_DIV-1][k]};
    end
  end

  for (genvar d = 0; d < QS; d++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        len[d+1] <= len[d];
        for (int k = 0; k < AX; k++) begin
          if (rem[d][k] >= {1'b0, len[d]}) begin
            rem[d+1][k] <= {rem[d][k][RB-1:0] - len[d], 1'b0};
            quo[d+1][k] <= {quo[d][k][QS-2:0], 1'b1};
          end else begin
            rem[d+1][k] <= {rem[d][k][RB-1:0], 1'b0};
            quo[d+1][k] <= {quo[d][k][QS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Side data shift line; magnitudes and signs load at stage 2, the zero flag
  // at the sum stage.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_p[S_MAG] <= mag_c;
      neg_p[S_MAG] <= neg_c;
      deg_p[S_SUM] <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
    end
  end

  for (genvar s = 0; s < D; s++) begin : g_side
    if (s != S_MAG) begin : g_mn
      always_ff @(posedge clk) begin
        if (en) begin
          mag_p[s] <= (s == 0) ? '0 : mag_p[(s == 0) ? 0 : s - 1];
          neg_p[s] <= (s == 0) ? '0 : neg_p[(s == 0) ? 0 : s - 1];
        end
      end
    end
    if (s != S_SUM) begin : g_dg
      always_ff @(posedge clk) begin
        if (en) begin
          deg_p[s] <= (s == 0) ? 1'b0 : deg_p[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  // Output register: restore the sign, force zeros for a degenerate triangle.
  logic [AX-1:0][NORMAL_WIDTH-1:0] comp;
  always_comb begin
    for (int k = 0; k < AX; k++) begin
      if (deg_p[D-2]) begin
        comp[k] = '0;
      end else if (neg_p[D-2][k]) begin
        comp[k] = -{1'b0, quo[QS][k]};
      end else begin
        comp[k] = {1'b0, quo[QS][k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal.nx         <= comp[0];
      normal.ny         <= comp[1];
      normal.nz         <= comp[2];
      normal.degenerate <= deg_p[D-2];
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for triangle_unit_normal: drives triangle requests and checks each
// unit normal request against an exact integer prediction. Depends on tun_pkg,
// tun_vtx_if, tun_nrm_if and the triangle_unit_normal top level.
`timescale 1ns / 1ps
module tb;
  localparam int CW = 16;
  localparam int NW = 16;
  localparam int FRAC = NW - tun_pkg::NORM_INT_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  // One triangle: vertex A, B, C, each with x, y, z.
  typedef struct {
    logic signed [CW-1:0] a [tun_pkg::AXES];
    logic signed [CW-1:0] b [tun_pkg::AXES];
    logic signed [CW-1:0] c [tun_pkg::AXES];
  } triangle_t;

  typedef struct {
    logic signed [NW-1:0] n [tun_pkg::AXES];
    logic                 degenerate;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle = 0;
  int   errors = 0;
  int   quiet_cycles = 0;

  tun_vtx_if #(.COORD_WIDTH(CW)) vtx ();
  tun_nrm_if #(.NORMAL_WIDTH(NW)) nrm ();

  triangle_unit_normal #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) dut (
    .clk(clk),
    .rst(rst),
    .vertices(vtx),
    .normal(nrm)
  );

  // The clock runs with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Triangles waiting to be sent, and normals waiting to be seen.
  triangle_t pending_tris[$];
  normal_t   expected_normals[$];

  // Exact unit normal: the cross product of the edges AB and AC, its integer
  // length, and each component scaled by 2^FRAC and truncated toward zero.
  function automatic normal_t unit_normal(triangle_t t);
    longint e1 [tun_pkg::AXES];
    longint e2 [tun_pkg::AXES];
    longint cr [tun_pkg::AXES];
    logic [159:0] mag [tun_pkg::AXES];
    logic [159:0] sum;
    logic [159:0] root;
    logic [159:0] cand;
    logic [159:0] quo;
    normal_t r;
    for (int k = 0; k < tun_pkg::AXES; k++) begin
      e1[k] = longint'(t.b[k]) - longint'(t.a[k]);
      e2[k] = longint'(t.c[k]) - longint'(t.a[k]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e2[0] * e1[2] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
    sum = '0;
    for (int k = 0; k < tun_pkg::AXES; k++) begin
      mag[k] = (cr[k] < 0) ? 160'(-cr[k]) : 160'(cr[k]);
      sum = sum + mag[k] * mag[k];
    end
    if (sum == 0) begin
      for (int k = 0; k < tun_pkg::AXES; k++) r.n[k] = '0;
      r.degenerate = 1'b1;
      return r;
    end
    // Bitwise integer square root, one root bit per step from the top.
    root = '0;
    for (int i = 2 * CW + 6; i >= 0; i--) begin
      cand = root | (160'(1) << i);
      if (cand * cand <= sum) root = cand;
    end
    for (int k = 0; k < tun_pkg::AXES; k++) begin
      quo = (mag[k] << FRAC) / root;
      r.n[k] = (cr[k] < 0) ? NW'(-quo) : NW'(quo);
    end
    r.degenerate = 1'b0;
    return r;
  endfunction

  // Idling is off in one window so that the pipeline also sees a solid stream.
  function automatic bit idle_now();
    if (cycle >= 200 && cycle < 700) return 1'b0;
    return $urandom_range(99) < 28;
  endfunction

  // Sampled at the rising edge, used by the driver at the falling edge.
  logic vtx_taken = 1'b0;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    vtx_taken <= vtx.valid && vtx.ready;
    if (vtx.valid && vtx.ready) begin
      expected_normals = {expected_normals, unit_normal(pending_tris[0])};
    end
    // Monitor: each normal request is compared with the oldest prediction.
    if (nrm.valid && nrm.ready) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected normal nx=%0d ny=%0d nz=%0d deg=%0b", $time,
                 nrm.nx, nrm.ny, nrm.nz, nrm.degenerate);
        errors++;
      end else begin
        normal_t want;
        want = expected_normals.pop_front();
        if (nrm.nx !== want.n[0] || nrm.ny !== want.n[1] || nrm.nz !== want.n[2] ||
            nrm.degenerate !== want.degenerate) begin
          $display("%0t: mismatch expected (%0d %0d %0d deg %0b) actual (%0d %0d %0d deg %0b)",
                   $time, want.n[0], want.n[1], want.n[2], want.degenerate,
                   nrm.nx, nrm.ny, nrm.nz, nrm.degenerate);
          errors++;
        end
      end
    end
    // Watchdog on cycles in which no request moves on either channel.
    if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready)) begin
      quiet_cycles <= 0;
    end else if (!rst && (pending_tris.size() != 0 || expected_normals.size() != 0)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Driver: retire the request accepted at the last rising edge, then present
  // the next one unless this cycle idles. A request that is shown but not yet
  // taken stays up. The valid is assigned once per step.
  always @(negedge clk) begin
    bit show;
    if (vtx_taken) pending_tris.pop_front();
    show = !rst && pending_tris.size() != 0 &&
           ((vtx.valid && !vtx_taken) || !idle_now());
    vtx.valid <= show;
    if (show) begin
      vtx.ax <= pending_tris[0].a[0];
      vtx.ay <= pending_tris[0].a[1];
      vtx.az <= pending_tris[0].a[2];
      vtx.bx <= pending_tris[0].b[0];
      vtx.by <= pending_tris[0].b[1];
      vtx.bz <= pending_tris[0].b[2];
      vtx.cx <= pending_tris[0].c[0];
      vtx.cy <= pending_tris[0].c[1];
      vtx.cz <= pending_tris[0].c[2];
    end
    nrm.ready <= !rst && !idle_now();
  end

  function automatic logic signed [CW-1:0] rand_coord(bit narrow);
    if (narrow) return CW'($signed($urandom_range(0, 1023)) - 512);
    return CW'($urandom);
  endfunction

  task automatic add_tri(int ax, int ay, int az, int bx, int by, int bz,
                         int cx, int cy, int cz);
    triangle_t t;
    t.a[0] = CW'(ax); t.a[1] = CW'(ay); t.a[2] = CW'(az);
    t.b[0] = CW'(bx); t.b[1] = CW'(by); t.b[2] = CW'(bz);
    t.c[0] = CW'(cx); t.c[1] = CW'(cy); t.c[2] = CW'(cz);
    pending_tris = {pending_tris, t};
  endtask

  initial begin
    triangle_t t;
    int kind;
    int scale;
    vtx.valid = 1'b0;
    vtx.ax = '0; vtx.ay = '0; vtx.az = '0;
    vtx.bx = '0; vtx.by = '0; vtx.bz = '0;
    vtx.cx = '0; vtx.cy = '0; vtx.cz = '0;
    nrm.ready = 1'b0;

    // Directed triangles: degenerate ones (all equal, coincident vertices,
    // collinear), the coordinate extremes, axis-aligned unit triangles in
    // every plane and both windings, and the largest possible cross product.
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_tri(5, 6, 7, 5, 6, 7, 100, -30, 9);
    add_tri(0, 0, 0, 256, 256, 256, 512, 512, 512);
    add_tri(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0);
    add_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);
    add_tri(0, 0, 0, 0, 256, 0, 0, 0, 256);
    add_tri(0, 0, 0, 0, 0, 256, 0, 256, 0);
    add_tri(0, 0, 0, 0, 0, 256, 256, 0, 0);
    add_tri(0, 0, 0, 256, 0, 0, 0, 0, 256);
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
    add_tri(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
    add_tri(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
    add_tri(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767);
    add_tri(0, 0, 0, 256, 256, 256, 256, -256, 0);
    add_tri(100, 200, 300, 101, 200, 300, 100, 201, 301);
    add_tri(-1, -1, -1, 0, 0, 0, -1, 0, -1);

    // Random triangles: mostly full-range or small ones, with some
    // degenerate and nearly flat ones mixed in.
    for (int i = 0; i < 650; i++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < tun_pkg::AXES; k++) begin
        t.a[k] = rand_coord(kind >= 5 && kind <= 7);
        t.b[k] = rand_coord(kind >= 5 && kind <= 7);
        t.c[k] = rand_coord(kind >= 5 && kind <= 7);
      end
      if (kind == 8) begin
        scale = $urandom_range(0, 3);
        for (int k = 0; k < tun_pkg::AXES; k++) begin
          t.a[k] = rand_coord(1'b1);
          t.b[k] = t.a[k] + rand_coord(1'b1) / 8;
          t.c[k] = CW'(t.a[k] + (t.b[k] - t.a[k]) * scale);
        end
      end else if (kind == 9) begin
        for (int k = 0; k < tun_pkg::AXES; k++) begin
          t.c[k] = CW'(int'(t.a[k]) + int'($urandom_range(0, 2)) - 1);
        end
      end
      pending_tris = {pending_tris, t};
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (pending_tris.size() == 0 && expected_normals.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
